// ===== rtl/pcpa_pkg.sv =====
// Shared constants, codes and controller/datapath types for the per-CPU page allocator.
package pcpa_pkg;

   // Default sizing of the allocator
   localparam int DEF_CPU_COUNT  = 8;
   localparam int DEF_MAX_PAGES  = 32768;
   localparam int DEF_PAGE_BYTES = 4096;

   // Fixed field widths
   localparam int ADDR_W    = 36;
   localparam int CPU_ID_W  = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_LOW_BOUND = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOP       = 1'd1;
   localparam logic [ADDR_W-1:0]    LOW_BOUND_RESET = 36'd0;
   localparam logic [ADDR_W-1:0]    TOP_RESET       = 36'd134217728;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;  // capture the request item
      logic check;     // range check, pick target list, prime divider
      logic div_step;  // advance page index divider
      logic head_rd;   // read head of target list
      logic push;      // link page in front of head
      logic link_rd;   // read link of popped page
      logic pop;       // advance head past popped page
      logic load_out;  // move result into output register
   } pcpa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_free;   // captured item is a free
      logic ok;        // check passed (address in range, or some list not empty)
      logic div_done;  // page index ready
      logic aligned;   // address is a whole multiple of the page size
   } pcpa_stat_type;

endpackage

// ===== rtl/per_cpu_page_allocator_with_steal.sv =====
// Top level of the per-CPU page allocator with stealing.
//
// Physical page allocator with one LIFO free list per CPU, handling one item at a
// time. A free item (kind 1) pushes the page onto its CPU's list unless the address
// is unaligned, below low_bound_addr, at or above top_addr, or beyond the page window
// of MAX_PAGES pages; such a free returns status 2 and changes nothing. An allocate
// item (kind 0) pops the requesting CPU's list, or else the list of the lowest-
// numbered other CPU that has a page (stolen = 1), or returns status 1 when every
// list is empty. A cpu_id at or above CPU_COUNT wraps modulo CPU_COUNT. Double frees
// are not detected. An item runs from acceptance to a loaded result through capture,
// check and list pick, then single-port registered reads of the head memory and, for
// an allocate, of the link memory, followed by the write-back. When PAGE_BYTES is
// not a power of two a free also passes through the bit-serial page index divider.
// A result waits in the output register while the next item is taken in; no
// clearing pass is needed after reset.
module per_cpu_page_allocator_with_steal #(
   parameter int CPU_COUNT  = pcpa_pkg::DEF_CPU_COUNT,
   parameter int MAX_PAGES  = pcpa_pkg::DEF_MAX_PAGES,
   parameter int PAGE_BYTES = pcpa_pkg::DEF_PAGE_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_write_en,
   input  logic [pcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcpa_pkg::ADDR_W-1:0]    csr_write_data,
   // request items
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [pcpa_pkg::CPU_ID_W-1:0]  req_cpu_id,
   input  logic [pcpa_pkg::ADDR_W-1:0]    req_page_addr,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [pcpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pcpa_pkg::ADDR_W-1:0]    rsp_granted_addr,
   output logic                           rsp_stolen
);
   import pcpa_pkg::*;

   pcpa_cmd_type  cmd;
   pcpa_stat_type stat;

   // Sequencer: walks capture, check, divider steps, head read, link access and result load
   pcpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Datapath: configuration, list heads and links, divider, result registers
   pcpa_dp #(
      .CPU_COUNT  (CPU_COUNT),
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_kind),
      .req_cpu_id       (req_cpu_id),
      .req_page_addr    (req_page_addr),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_granted_addr (rsp_granted_addr),
      .rsp_stolen       (rsp_stolen)
   );

   // Busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in flight");

   // Failed items carry no page and no steal flag
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> ((rsp_granted_addr == '0) && !rsp_stolen))
      else $error("failed result carries a page");

   // A stolen page is always a successful grant
   a_steal_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stolen) |-> (rsp_status == ST_OK))
      else $error("steal flag on a failed result");

   // At most one datapath step per cycle
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.check, cmd.div_step, cmd.head_rd,
                cmd.push, cmd.link_rd, cmd.pop, cmd.load_out}))
      else $error("overlapping datapath commands");

endmodule

// ===== rtl/pcpa_ctrl.sv =====
// Sequencing state machine of the per-CPU page allocator.
module pcpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pcpa_pkg::pcpa_cmd_type cmd,
   input  pcpa_pkg::pcpa_stat_type stat
);
   import pcpa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_DIV, S_HRD, S_PUSH, S_LRD, S_POP, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (!stat.ok) state_in = S_FINISH;
            else if (stat.is_free) state_in = S_DIV;
            else state_in = S_HRD;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = stat.aligned ? S_HRD : S_FINISH;
         end
         S_HRD: begin
            cmd.head_rd = 1'b1;
            state_in    = stat.is_free ? S_PUSH : S_LRD;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_FINISH;
         end
         S_LRD: begin
            cmd.link_rd = 1'b1;
            state_in    = S_POP;
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/pcpa_dp.sv =====
// Datapath of the per-CPU page allocator: registers, list memories, divider, result.
module pcpa_dp #(
   parameter int CPU_COUNT  = pcpa_pkg::DEF_CPU_COUNT,
   parameter int MAX_PAGES  = pcpa_pkg::DEF_MAX_PAGES,
   parameter int PAGE_BYTES = pcpa_pkg::DEF_PAGE_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [pcpa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pcpa_pkg::ADDR_W-1:0]     csr_write_data,
   input  logic                            req_kind,
   input  logic [pcpa_pkg::CPU_ID_W-1:0]   req_cpu_id,
   input  logic [pcpa_pkg::ADDR_W-1:0]     req_page_addr,
   input  pcpa_pkg::pcpa_cmd_type          cmd,
   output pcpa_pkg::pcpa_stat_type         stat,
   output logic [pcpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pcpa_pkg::ADDR_W-1:0]     rsp_granted_addr,
   output logic                            rsp_stolen
);
   import pcpa_pkg::*;

   localparam int    CW        = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
   localparam int    IW        = $clog2(MAX_PAGES);
   localparam int    LW        = IW + 1;
   localparam longint WIN_BYTES = longint'(MAX_PAGES) * longint'(PAGE_BYTES);
   localparam int    AW        = $clog2(WIN_BYTES);
   localparam int    PSH       = $clog2(PAGE_BYTES);
   localparam bit    PB_POW2   = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);

   // Configuration
   logic [ADDR_W-1:0] low_ff, top_ff;

   // Captured item
   logic              kind_ff;
   logic [CW-1:0]     cpu_ff;
   logic [ADDR_W-1:0] addr_ff;

   // List state
   logic [CPU_COUNT-1:0] hv_ff;
   logic [IW-1:0]        heads_mem [CPU_COUNT];
   logic [LW-1:0]        links_mem [MAX_PAGES];
   logic [IW-1:0]        head_q;
   logic [LW-1:0]        link_q;

   // Work registers
   logic [CW-1:0]       tgt_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [ADDR_W-1:0]   grant_ff;
   logic                stolen_ff;

   // Output register
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_granted_ff;
   logic                rsp_stolen_ff;

   logic [6:0]          cpu_red;
   logic [CW-1:0]       other_cpu;
   logic                other_found;
   logic                range_bad;
   logic [STATUS_W-1:0] chk_code;
   logic [IW-1:0]       page_idx;
   logic                aligned;
   logic                div_done;

   // Fold cpu id into range by repeated subtraction
   always_comb begin
      cpu_red = {4'b0, req_cpu_id};
      for (int i = 0; i < 8; i++) begin
         if (cpu_red >= 7'(CPU_COUNT)) cpu_red = cpu_red - 7'(CPU_COUNT);
      end
   end

   // Lowest-numbered other cpu with a non-empty list
   always_comb begin
      other_cpu   = '0;
      other_found = 1'b0;
      for (int c = CPU_COUNT - 1; c >= 0; c--) begin
         if (hv_ff[c] && (CW'(c) != cpu_ff)) begin
            other_cpu   = CW'(c);
            other_found = 1'b1;
         end
      end
   end

   assign range_bad = (addr_ff < low_ff) || (addr_ff >= top_ff) ||
                      ({1'b0, addr_ff} >= (ADDR_W + 1)'(WIN_BYTES));

   always_comb begin
      if (kind_ff == KIND_FREE) chk_code = range_bad ? ST_INVALID : ST_OK;
      else chk_code = (hv_ff[cpu_ff] || other_found) ? ST_OK : ST_OOM;
   end

   // Page index of the captured address
   generate
      if (PB_POW2) begin : g_shift
         assign page_idx = addr_ff[PSH +: IW];
         assign aligned  = (addr_ff[PSH-1:0] == '0);
         assign div_done = 1'b1;
      end else begin : g_div
         localparam longint DVS_INIT = longint'(PAGE_BYTES) << (IW - 1);
         localparam int     NW       = $clog2(IW + 1);
         logic [AW-1:0] rem_ff, dvs_ff;
         logic [IW-1:0] quo_ff;
         logic [NW-1:0] cnt_ff;
         logic          fits;

         assign fits = (rem_ff >= dvs_ff);

         // Restoring division, one quotient bit per cycle
         always_ff @(posedge clock) begin
            if (cmd.check) begin
               rem_ff <= addr_ff[AW-1:0];
               dvs_ff <= AW'(DVS_INIT);
               quo_ff <= '0;
               cnt_ff <= '0;
            end else if (cmd.div_step && (cnt_ff != NW'(IW))) begin
               if (fits) rem_ff <= rem_ff - dvs_ff;
               quo_ff <= {quo_ff[IW-2:0], fits};
               dvs_ff <= dvs_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end

         assign page_idx = quo_ff;
         assign aligned  = (rem_ff == '0);
         assign div_done = (cnt_ff == NW'(IW));
      end
   endgenerate

   assign stat.is_free  = (kind_ff == KIND_FREE);
   assign stat.ok       = (chk_code == ST_OK);
   assign stat.div_done = div_done;
   assign stat.aligned  = aligned;

   // Configuration registers and list valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= LOW_BOUND_RESET;
         top_ff <= TOP_RESET;
         hv_ff  <= '0;
      end else begin
         if (csr_write_en && (csr_index == REG_LOW_BOUND)) low_ff <= csr_write_data;
         if (csr_write_en && (csr_index == REG_TOP)) top_ff <= csr_write_data;
         if (cmd.push) hv_ff[tgt_ff] <= 1'b1;
         else if (cmd.pop) hv_ff[tgt_ff] <= link_q[IW];
      end
   end

   // Item capture and work registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         cpu_ff  <= cpu_red[CW-1:0];
         addr_ff <= req_page_addr;
      end
      if (cmd.check) begin
         status_ff <= chk_code;
         grant_ff  <= '0;
         stolen_ff <= (kind_ff == KIND_ALLOC) && !hv_ff[cpu_ff] && other_found;
         tgt_ff    <= ((kind_ff == KIND_ALLOC) && !hv_ff[cpu_ff]) ? other_cpu : cpu_ff;
      end
      if (cmd.div_step && div_done && !aligned) status_ff <= ST_INVALID;
      if (cmd.link_rd) grant_ff <= ADDR_W'(head_q) * ADDR_W'(PAGE_BYTES);
   end

   // Head memory
   always_ff @(posedge clock) begin
      if (cmd.push) heads_mem[tgt_ff] <= page_idx;
      else if (cmd.pop) heads_mem[tgt_ff] <= link_q[IW-1:0];
      if (cmd.head_rd) head_q <= heads_mem[tgt_ff];
   end

   // Link memory
   always_ff @(posedge clock) begin
      if (cmd.push) links_mem[page_idx] <= {hv_ff[tgt_ff], head_q};
      if (cmd.link_rd) link_q <= links_mem[head_q];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff  <= status_ff;
         rsp_granted_ff <= grant_ff;
         rsp_stolen_ff  <= stolen_ff;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_addr = rsp_granted_ff;
   assign rsp_stolen       = rsp_stolen_ff;

endmodule

// ===== sim/pcpa_alloc_checker.sv =====
`timescale 1ns / 100ps
// Checker for the per-CPU page allocator: mirrors the free lists and compares every result item.
module pcpa_alloc_checker
   import pcpa_pkg::*;
#(
   parameter int CPU_COUNT  = DEF_CPU_COUNT,
   parameter int MAX_PAGES  = DEF_MAX_PAGES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_write_data,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_kind,
   input  logic [CPU_ID_W-1:0]  req_cpu_id,
   input  logic [ADDR_W-1:0]    req_page_addr,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic [ADDR_W-1:0]    rsp_granted_addr,
   input  logic                 rsp_stolen,
   output int                   error_count,
   output int                   outstanding
);

   localparam int IDX_W      = $clog2(MAX_PAGES);
   localparam int REPORT_CAP = 60;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted_addr;
      logic                stolen;
   } outcome_t;

   logic [IDX_W-1:0]  head_page [CPU_COUNT];
   bit                head_live [CPU_COUNT];
   logic [IDX_W-1:0]  link_page [MAX_PAGES];
   bit                link_live [MAX_PAGES];
   logic [ADDR_W-1:0] low_bound;
   logic [ADDR_W-1:0] top_bound;
   outcome_t          awaited_outcomes [$];

   // Apply one request to the mirrored lists and return the result it must produce.
   function automatic outcome_t serve_request(input logic kind,
                                              input logic [CPU_ID_W-1:0] cpu_field,
                                              input logic [ADDR_W-1:0] addr);
      outcome_t        res;
      int              cpu;
      int              src;
      longint unsigned page;
      res        = '0;
      res.status = ST_OK;
      cpu        = int'(cpu_field) % CPU_COUNT;
      if (kind == KIND_FREE) begin
         page = addr / PAGE_BYTES;
         if (addr % PAGE_BYTES != 0 || addr < low_bound || addr >= top_bound ||
             page >= MAX_PAGES) begin
            res.status = ST_INVALID;
         end else begin
            link_page[page] = head_page[cpu];
            link_live[page] = head_live[cpu];
            head_page[cpu]  = IDX_W'(page);
            head_live[cpu]  = 1'b1;
         end
         return res;
      end
      // own list first, then the lowest-numbered other list holding a page
      src = -1;
      if (head_live[cpu]) begin
         src = cpu;
      end else begin
         for (int c = 0; c < CPU_COUNT; c++)
            if (src < 0 && c != cpu && head_live[c]) src = c;
      end
      if (src < 0) begin
         res.status = ST_OOM;
      end else begin
         page              = head_page[src];
         head_live[src]    = link_live[page];
         head_page[src]    = link_live[page] ? link_page[page] : '0;
         res.granted_addr  = ADDR_W'(page * PAGE_BYTES);
         res.stolen        = (src != cpu);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         for (int c = 0; c < CPU_COUNT; c++) begin
            head_page[c] = '0;
            head_live[c] = 1'b0;
         end
         low_bound = LOW_BOUND_RESET;
         top_bound = TOP_RESET;
         awaited_outcomes.delete();
         error_count = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_LOW_BOUND: low_bound = csr_write_data;
               REG_TOP:       top_bound = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_CAP)
                  $error("unrequested result: status %0d granted_addr 0x%09h stolen %0d",
                         rsp_status, rsp_granted_addr, rsp_stolen);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  error_count++;
                  if (error_count <= REPORT_CAP)
                     $error("status: expected %0d, got %0d", want.status, rsp_status);
               end
               if (rsp_granted_addr !== want.granted_addr) begin
                  error_count++;
                  if (error_count <= REPORT_CAP)
                     $error("granted_addr: expected 0x%09h, got 0x%09h",
                            want.granted_addr, rsp_granted_addr);
               end
               if (rsp_stolen !== want.stolen) begin
                  error_count++;
                  if (error_count <= REPORT_CAP)
                     $error("stolen: expected %0d, got %0d", want.stolen, rsp_stolen);
               end
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(serve_request(req_kind, req_cpu_id, req_page_addr));
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

// ===== sim/tb_per_cpu_page_allocator_with_steal.sv =====
`timescale 1ns / 100ps
// Testbench top for the per-CPU page allocator: stimulus, configuration phases and verdict.
module tb_per_cpu_page_allocator_with_steal;
   import pcpa_pkg::*;

   localparam longint unsigned PAGE  = DEF_PAGE_BYTES;
   localparam longint unsigned PAGES = DEF_MAX_PAGES;
   // cycles with no accepted item before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // settle time after the last result
   localparam int TAIL_CYCLES = 24;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = REG_LOW_BOUND;
   logic [ADDR_W-1:0]    csr_write_data = '0;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_kind       = KIND_ALLOC;
   logic [CPU_ID_W-1:0]  req_cpu_id     = '0;
   logic [ADDR_W-1:0]    req_page_addr  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_granted_addr;
   logic                 rsp_stolen;

   int                   send_idle_pct  = 9;
   int                   recv_idle_pct  = 59;
   int                   quiet_cycles   = 0;
   int                   mismatches;
   int                   outstanding;
   logic [STATUS_W-1:0]  last_status    = ST_OK;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   per_cpu_page_allocator_with_steal u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_cpu_id       (req_cpu_id),
      .req_page_addr    (req_page_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_addr (rsp_granted_addr),
      .rsp_stolen       (rsp_stolen)
   );

   pcpa_alloc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_cpu_id       (req_cpu_id),
      .req_page_addr    (req_page_addr),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_addr (rsp_granted_addr),
      .rsp_stolen       (rsp_stolen),
      .error_count      (mismatches),
      .outstanding      (outstanding)
   );

   // Receiver: drop ready at random, at the rate of the current phase.
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // Remember the status of the latest result; the list flush steers on it.
   always @(posedge clock)
      if (rsp_valid && rsp_ready) last_status <= rsp_status;

   // Watchdog: any accepted item or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_per_cpu_page_allocator_with_steal NOT OK");
            $finish;
         end
      end
   end

   function automatic logic [ADDR_W-1:0] random_addr();
      return {4'($urandom_range(15)), 32'($urandom)};
   endfunction

   // Present one request item and hold it until accepted. Called at a rising
   // edge; returns at the edge that accepts the item, with valid still high.
   task automatic offer_request(input logic kind, input logic [CPU_ID_W-1:0] cpu,
                                input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_cpu_id    <= cpu;
      req_page_addr <= addr;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Allocate one page at a time until the block reports out of memory, so that
   // the next phase starts from empty lists and never frees a page still held.
   task automatic empty_all_lists();
      int tries;
      tries = 0;
      do begin
         offer_request(KIND_ALLOC, CPU_ID_W'($urandom_range(7)), random_addr());
         wait_quiet();
         tries++;
      end while (last_status != ST_OOM && tries < 4000);
   endtask

   // One configuration phase: flush, write both bounds, then random traffic.
   task automatic run_segment(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                              input int count);
      longint unsigned     lo_pg;
      longint unsigned     hi_pg;
      longint unsigned     cursor;
      bit                  has_window;
      int                  alloc_pct;
      int                  burst_left;
      int                  pick;
      logic                kind;
      logic [CPU_ID_W-1:0] cpu;
      logic [ADDR_W-1:0]   addr;
      wait_quiet();
      empty_all_lists();
      // write the bounds while the block is idle
      csr_write_en   <= 1'b1;
      csr_index      <= REG_LOW_BOUND;
      csr_write_data <= lo;
      @(posedge clock);
      csr_index      <= REG_TOP;
      csr_write_data <= hi;
      @(posedge clock);
      csr_write_en   <= 1'b0;

      // pages that a free may legally push in this phase
      lo_pg = (longint'(lo) + PAGE - 1) / PAGE;
      hi_pg = (longint'(hi) + PAGE - 1) / PAGE;
      if (hi_pg > PAGES) hi_pg = PAGES;
      has_window = (lo_pg < hi_pg);
      cursor     = lo_pg;
      burst_left = 0;
      alloc_pct  = 50;

      for (int n = 0; n < count; n++) begin
         // alternate free-heavy and alloc-heavy bursts so lists fill and run dry
         if (burst_left == 0) begin
            alloc_pct  = $urandom_range(1) ? 70 : 30;
            burst_left = $urandom_range(20, 60);
         end
         burst_left--;
         // now and then hold off until the block has answered everything
         if ($urandom_range(199) == 0) wait_quiet();

         addr = random_addr();
         cpu  = CPU_ID_W'($urandom_range(7));
         if ($urandom_range(99) < alloc_pct) begin
            kind = KIND_ALLOC;
         end else begin
            kind = KIND_FREE;
            pick = $urandom_range(99);
            if (has_window && pick < 80) begin
               // fresh page, mostly onto a few lists so other CPUs must steal
               addr = ADDR_W'(cursor * PAGE);
               cursor += $urandom_range(1, 3);
               if (cursor >= hi_pg) cursor = lo_pg;
               if ($urandom_range(3) != 0) cpu = CPU_ID_W'($urandom_range(2));
            end else if (has_window && pick < 88) begin
               addr = ADDR_W'(cursor * PAGE + $urandom_range(1, int'(PAGE) - 1));
            end else if (pick < 95) begin
               // just outside or on the bounds and the page window
               case ($urandom_range(5))
                  0: addr = lo - ADDR_W'(PAGE);
                  1: addr = lo - 1'b1;
                  2: addr = hi;
                  3: addr = hi - ADDR_W'(PAGE);
                  4: addr = ADDR_W'(PAGES * PAGE);
                  default: addr = 36'hF_FFFF_F000;
               endcase
            end
         end
         offer_request(kind, cpu, addr);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset bounds: empty lists report out of memory
      offer_request(KIND_ALLOC, 3'd0, 36'h0);
      offer_request(KIND_ALLOC, 3'd7, 36'hF_FFFF_FFFF);
      // page zero, unaligned, at and above the top bound, last page
      offer_request(KIND_FREE,  3'd0, 36'h0);
      offer_request(KIND_FREE,  3'd1, 36'hF_FFFF_FFFF);
      offer_request(KIND_FREE,  3'd1, 36'hF_FFFF_F000);
      offer_request(KIND_FREE,  3'd1, 36'h800_0000);
      offer_request(KIND_FREE,  3'd1, 36'h000_0001);
      offer_request(KIND_FREE,  3'd7, 36'h7FF_F000);
      offer_request(KIND_FREE,  3'd3, 36'h000_3000);
      // page zero granted, then steals from the lowest non-empty other list
      offer_request(KIND_ALLOC, 3'd0, 36'h0);
      offer_request(KIND_ALLOC, 3'd0, 36'h0);
      offer_request(KIND_ALLOC, 3'd5, 36'h0);
      offer_request(KIND_ALLOC, 3'd5, 36'h0);
      // double free makes a self loop; re-pushing the page elsewhere ends it
      offer_request(KIND_FREE,  3'd2, 36'h000_5000);
      offer_request(KIND_FREE,  3'd2, 36'h000_5000);
      offer_request(KIND_ALLOC, 3'd2, 36'h0);
      offer_request(KIND_ALLOC, 3'd2, 36'h0);
      offer_request(KIND_FREE,  3'd4, 36'h000_5000);
      offer_request(KIND_ALLOC, 3'd2, 36'h0);
      offer_request(KIND_ALLOC, 3'd4, 36'h0);
      offer_request(KIND_ALLOC, 3'd6, 36'h0);
      // last in, first out
      offer_request(KIND_FREE,  3'd6, 36'h000_1000);
      offer_request(KIND_FREE,  3'd6, 36'h000_2000);
      offer_request(KIND_ALLOC, 3'd6, 36'h0);
      offer_request(KIND_ALLOC, 3'd6, 36'h0);

      // Sender mostly busy, receiver often stalled
      run_segment(LOW_BOUND_RESET, TOP_RESET, 280);
      run_segment(36'h010_0000, 36'h040_0000, 280);

      // Sender often idle, receiver mostly ready
      send_idle_pct = 59;
      recv_idle_pct = 9;
      run_segment(36'h0, 36'hF_FFFF_FFFF, 280);
      run_segment(36'hF_FFFF_FFFF, 36'hF_FFFF_FFFF, 80);
      run_segment(36'h7F0_0000, 36'h801_0000, 230);

      // Full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segment(36'h000_0123, 36'h020_0800, 280);
      run_segment(36'h0, 36'h0, 80);
      run_segment(LOW_BOUND_RESET, TOP_RESET, 300);

      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_per_cpu_page_allocator_with_steal OK");
      else
         $display("tb_per_cpu_page_allocator_with_steal NOT OK");
      $finish;
   end

endmodule
